// File: hdl/a2d_pkg.sv
package a2d_pkg;

    localparam int COEF_WIDTH_DEF  = 32;
    localparam int FRAC_BITS_DEF   = 16;
    localparam int ANGLE_BITS_DEF  = 16;
    localparam int ARG_WIDTH       = 32;
    localparam int OUT_WIDTH       = 32;
    localparam int ANGLE_FIELD     = 16;
    localparam int CORDIC_STEPS    = 16;
    localparam int STEP_BITS       = 4;

    localparam logic [2:0] FUNC_SET       = 3'd0;
    localparam logic [2:0] FUNC_ROTATE    = 3'd1;
    localparam logic [2:0] FUNC_SCALE     = 3'd2;
    localparam logic [2:0] FUNC_TRANSLATE = 3'd3;
    localparam logic [2:0] FUNC_MAP       = 3'd4;

    typedef struct packed {
        logic [2:0]                   func;
        logic signed [ARG_WIDTH-1:0]  arg_a;
        logic signed [ARG_WIDTH-1:0]  arg_b;
        logic signed [ARG_WIDTH-1:0]  arg_c;
        logic signed [ARG_WIDTH-1:0]  arg_d;
        logic signed [ARG_WIDTH-1:0]  arg_e;
        logic signed [ARG_WIDTH-1:0]  arg_f;
        logic [ANGLE_FIELD-1:0]       angle;
    } a2d_in_t;

    typedef struct packed {
        logic signed [OUT_WIDTH-1:0] x_out;
        logic signed [OUT_WIDTH-1:0] y_out;
        logic                        overflow;
    } a2d_out_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CORDIC,
        ST_SC,
        ST_P0,
        ST_P1,
        ST_P2,
        ST_P3,
        ST_COMMIT,
        ST_OUT
    } a2d_state_t;

    // command from controller to datapath
    typedef struct packed {
        logic       load;
        logic       cordic_start;
        logic       cordic_step;
        logic       sc_latch;
        logic [1:0] pass_sel;
        logic       pass_en;
        logic       commit;
        logic       out_load;
    } a2d_cmd_t;

    typedef struct packed {
        logic [2:0] func;
        logic       cordic_last;
    } a2d_sts_t;

    function automatic logic [31:0] atan_turn(input logic [STEP_BITS-1:0] i);
        logic [31:0] r;
        begin
            unique case (i)
                4'd0:  r = 32'h20000000;
                4'd1:  r = 32'h12E4051E;
                4'd2:  r = 32'h09FB385B;
                4'd3:  r = 32'h051111D4;
                4'd4:  r = 32'h028B0D43;
                4'd5:  r = 32'h0145D7E1;
                4'd6:  r = 32'h00A2F61E;
                4'd7:  r = 32'h00517C55;
                4'd8:  r = 32'h0028BE53;
                4'd9:  r = 32'h00145F2F;
                4'd10: r = 32'h000A2F98;
                4'd11: r = 32'h000517CC;
                4'd12: r = 32'h00028BE6;
                4'd13: r = 32'h000145F3;
                4'd14: r = 32'h0000A2FA;
                default: r = 32'h0000517D;
            endcase
            return r;
        end
    endfunction

endpackage

// File: hdl/a2d_ctrl.sv
module a2d_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_stall,
    output logic            out_valid,
    input  logic            out_stall,
    input  a2d_pkg::a2d_sts_t sts,
    output a2d_pkg::a2d_cmd_t cmd
);
    import a2d_pkg::*;

    a2d_state_t state_reg, state_next;
    logic       out_valid_reg, out_valid_next;
    logic       accept;

    assign accept    = in_valid && !in_stall;
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_CORDIC;
                end
            end
            ST_CORDIC:
            begin
                priority if (sts.func == FUNC_ROTATE)
                begin
                    if (sts.cordic_last)
                    begin
                        state_next = ST_SC;
                    end
                end
                else if (sts.func == FUNC_SET || sts.func == FUNC_SCALE ||
                         sts.func == FUNC_TRANSLATE || sts.func == FUNC_MAP)
                begin
                    state_next = ST_P0;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_SC:     state_next = ST_P0;
            ST_P0:     state_next = ST_P1;
            ST_P1:     state_next = ST_P2;
            ST_P2:     state_next = ST_P3;
            ST_P3:     state_next = ST_COMMIT;
            ST_COMMIT: state_next = (sts.func == FUNC_MAP) ? ST_OUT : ST_IDLE;
            ST_OUT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd            = '0;
        in_stall       = (state_reg != ST_IDLE);
        out_valid_next = out_valid_reg && out_stall;
        cmd.load       = accept;
        unique case (state_reg)
            ST_CORDIC:
            begin
                cmd.cordic_step = (sts.func == FUNC_ROTATE);
            end
            ST_SC:     cmd.sc_latch = 1'b1;
            ST_P0:
            begin
                cmd.pass_en  = 1'b1;
                cmd.pass_sel = 2'd0;
            end
            ST_P1:
            begin
                cmd.pass_en  = 1'b1;
                cmd.pass_sel = 2'd1;
            end
            ST_P2:
            begin
                cmd.pass_en  = 1'b1;
                cmd.pass_sel = 2'd2;
            end
            ST_P3:
            begin
                cmd.pass_en  = 1'b1;
                cmd.pass_sel = 2'd3;
            end
            ST_COMMIT: cmd.commit = 1'b1;
            ST_OUT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                end
            end
            default:   cmd.cordic_start = accept;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_stall |=> out_valid_reg)
        else $error("result dropped while stalled");
    a_busy_stall: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != ST_IDLE |-> in_stall)
        else $error("input taken while busy");
    a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> state_reg == ST_CORDIC)
        else $error("accept did not start work");

endmodule

// File: hdl/a2d_datapath.sv
module a2d_datapath #(
    parameter int COEF_WIDTH = a2d_pkg::COEF_WIDTH_DEF,
    parameter int FRAC_BITS  = a2d_pkg::FRAC_BITS_DEF,
    parameter int ANGLE_BITS = a2d_pkg::ANGLE_BITS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  a2d_pkg::a2d_in_t   in_data,
    input  a2d_pkg::a2d_cmd_t  cmd,
    output a2d_pkg::a2d_sts_t  sts,
    output a2d_pkg::a2d_out_t  out_data
);
    import a2d_pkg::*;

    localparam int CW  = COEF_WIDTH;
    localparam int MW  = (CW > ARG_WIDTH ? CW : ARG_WIDTH);
    localparam int PW  = 2 * MW + 2;
    localparam int CX  = 34;
    localparam logic signed [CW-1:0] ONE_C = CW'(1) <<< FRAC_BITS;

    a2d_in_t                 cmd_reg;
    logic signed [CW-1:0]    m_reg [6];
    logic signed [MW-1:0]    n_reg [4];
    logic signed [CX-1:0]    cx_reg, cy_reg;
    logic signed [CX-1:0]    cz_reg;
    logic                    flip_reg;
    logic [STEP_BITS-1:0]    step_reg;
    logic signed [MW-1:0]    s_reg, c_reg;
    logic                    ov_reg;
    a2d_out_t                out_reg;

    // cordic iteration
    logic signed [CX-1:0]    dxs, dys;
    logic signed [CX-1:0]    at;
    logic [31:0]             z0;
    logic signed [CX-1:0]    c_rnd, s_rnd, fx, fy;

    always_comb
    begin
        dxs   = cy_reg >>> step_reg;
        dys   = cx_reg >>> step_reg;
        at    = CX'(atan_turn(step_reg));
        z0    = 32'(in_data.angle[ANGLE_BITS-1:0]) << (32 - ANGLE_BITS);
        fx    = flip_reg ? -cx_reg : cx_reg;
        fy    = flip_reg ? -cy_reg : cy_reg;
        c_rnd = (fx + (CX'(1) <<< (29 - FRAC_BITS))) >>> (30 - FRAC_BITS);
        s_rnd = (fy + (CX'(1) <<< (29 - FRAC_BITS))) >>> (30 - FRAC_BITS);
    end

    // one pass: a1*b1 + a2*b2 + c*one, rounded, saturated
    logic signed [MW-1:0]    a1, b1, a2, b2, cc;
    logic signed [PW-1:0]    acc;
    logic signed [PW-1:0]    shf;
    logic signed [CW-1:0]    sat_c;
    logic signed [OUT_WIDTH-1:0] sat_o;
    logic                    ovc, ovo;
    logic signed [MW-1:0]    xa, ya;

    always_comb
    begin
        xa = MW'(cmd_reg.arg_a);
        ya = MW'(cmd_reg.arg_b);
        a1 = '0; b1 = '0; a2 = '0; b2 = '0; cc = '0;
        unique case (cmd_reg.func)
            FUNC_SET:
            begin
                unique case (cmd.pass_sel)
                    2'd0: cc = MW'(cmd_reg.arg_a);
                    2'd1: cc = MW'(cmd_reg.arg_b);
                    2'd2: cc = MW'(cmd_reg.arg_c);
                    default: cc = MW'(cmd_reg.arg_d);
                endcase
            end
            FUNC_ROTATE:
            begin
                a1 = cmd.pass_sel[1] ? -s_reg : c_reg;
                a2 = cmd.pass_sel[1] ? c_reg : s_reg;
                b1 = MW'(m_reg[{2'b00, cmd.pass_sel[0]}]);
                b2 = MW'(m_reg[{2'b01, cmd.pass_sel[0]}]);
            end
            FUNC_SCALE:
            begin
                a1 = MW'(m_reg[{1'b0, cmd.pass_sel}]);
                b1 = cmd.pass_sel[1] ? ya : xa;
            end
            FUNC_TRANSLATE, FUNC_MAP:
            begin
                a1 = (cmd_reg.func == FUNC_MAP) ? xa : MW'(cmd_reg.arg_e);
                a2 = (cmd_reg.func == FUNC_MAP) ? ya : MW'(cmd_reg.arg_f);
                b1 = MW'(m_reg[{2'b00, cmd.pass_sel[0]}]);
                b2 = MW'(m_reg[{2'b01, cmd.pass_sel[0]}]);
                cc = MW'(m_reg[{2'b10, cmd.pass_sel[0]}]);
            end
            default: cc = '0;
        endcase
        acc = PW'(a1) * PW'(b1) + PW'(a2) * PW'(b2) + (PW'(cc) <<< FRAC_BITS)
            + (PW'(1) <<< (FRAC_BITS - 1));
        shf = acc >>> FRAC_BITS;
        ovc = (shf > $signed(PW'({1'b0, {(CW-1){1'b1}}}))) ||
              (shf < -(PW'(1) <<< (CW - 1)));
        sat_c = ovc ? (shf[PW-1] ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}})
                    : shf[CW-1:0];
        ovo = (shf > $signed(PW'({1'b0, {(OUT_WIDTH-1){1'b1}}}))) ||
              (shf < -(PW'(1) <<< (OUT_WIDTH - 1)));
        sat_o = ovo ? (shf[PW-1] ? {1'b1, {(OUT_WIDTH-1){1'b0}}}
                                 : {1'b0, {(OUT_WIDTH-1){1'b1}}})
                    : shf[OUT_WIDTH-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            cmd_reg  <= in_data;
            step_reg <= '0;
            cx_reg   <= CX'(34'sh26DD3B6A);
            cy_reg   <= '0;
            if (((z0 + 32'h40000000) & 32'h80000000) != 32'd0)
            begin
                flip_reg <= 1'b1;
                cz_reg   <= CX'($signed(z0 - 32'h80000000));
            end
            else
            begin
                flip_reg <= 1'b0;
                cz_reg   <= CX'($signed(z0));
            end
        end
        else if (cmd.cordic_step)
        begin
            step_reg <= step_reg + 1'b1;
            if (!cz_reg[CX-1])
            begin
                cx_reg <= cx_reg - dxs;
                cy_reg <= cy_reg + dys;
                cz_reg <= cz_reg - at;
            end
            else
            begin
                cx_reg <= cx_reg + dxs;
                cy_reg <= cy_reg - dys;
                cz_reg <= cz_reg + at;
            end
        end
        if (cmd.sc_latch)
        begin
            c_reg <= MW'(c_rnd);
            s_reg <= MW'(s_rnd);
        end
        if (cmd.pass_en)
        begin
            n_reg[cmd.pass_sel] <= (cmd_reg.func == FUNC_MAP) ? MW'(sat_o) : MW'(sat_c);
            if (cmd.pass_sel == 2'd0)
            begin
                ov_reg <= ovo;
            end
            else
            begin
                ov_reg <= ov_reg | ovo;
            end
        end
        if (cmd.out_load)
        begin
            out_reg.x_out    <= OUT_WIDTH'(n_reg[0]);
            out_reg.y_out    <= OUT_WIDTH'(n_reg[1]);
            out_reg.overflow <= ov_reg;
        end
    end

    // set also writes offsets: store args e,f saturated alongside
    logic signed [CW-1:0] se, sf;
    always_comb
    begin
        se = (CW >= ARG_WIDTH) ? CW'(cmd_reg.arg_e) : CW'(cmd_reg.arg_e);
        sf = (CW >= ARG_WIDTH) ? CW'(cmd_reg.arg_f) : CW'(cmd_reg.arg_f);
        if (CW < ARG_WIDTH)
        begin
            if (MW'(cmd_reg.arg_e) > $signed(MW'({1'b0, {(CW-1){1'b1}}})))
                se = {1'b0, {(CW-1){1'b1}}};
            else if (MW'(cmd_reg.arg_e) < -(MW'(1) <<< (CW - 1)))
                se = {1'b1, {(CW-1){1'b0}}};
            if (MW'(cmd_reg.arg_f) > $signed(MW'({1'b0, {(CW-1){1'b1}}})))
                sf = {1'b0, {(CW-1){1'b1}}};
            else if (MW'(cmd_reg.arg_f) < -(MW'(1) <<< (CW - 1)))
                sf = {1'b1, {(CW-1){1'b0}}};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_reg[0] <= ONE_C;
            m_reg[1] <= '0;
            m_reg[2] <= '0;
            m_reg[3] <= ONE_C;
            m_reg[4] <= '0;
            m_reg[5] <= '0;
        end
        else if (cmd.commit)
        begin
            unique case (cmd_reg.func)
                FUNC_SET:
                begin
                    m_reg[0] <= CW'(n_reg[0]);
                    m_reg[1] <= CW'(n_reg[1]);
                    m_reg[2] <= CW'(n_reg[2]);
                    m_reg[3] <= CW'(n_reg[3]);
                    m_reg[4] <= se;
                    m_reg[5] <= sf;
                end
                FUNC_ROTATE, FUNC_SCALE:
                begin
                    m_reg[0] <= CW'(n_reg[0]);
                    m_reg[1] <= CW'(n_reg[1]);
                    m_reg[2] <= CW'(n_reg[2]);
                    m_reg[3] <= CW'(n_reg[3]);
                end
                FUNC_TRANSLATE:
                begin
                    m_reg[4] <= CW'(n_reg[0]);
                    m_reg[5] <= CW'(n_reg[1]);
                end
                default: m_reg[0] <= m_reg[0];
            endcase
        end
    end

    assign sts.func        = cmd_reg.func;
    assign sts.cordic_last = (step_reg == STEP_BITS'(CORDIC_STEPS - 1));
    assign out_data        = out_reg;

    a_step_rot: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.cordic_step |-> cmd_reg.func == FUNC_ROTATE)
        else $error("cordic stepped outside rotate");
    a_commit_pass: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |-> $past(cmd.pass_en) && $past(cmd.pass_sel) == 2'd3)
        else $error("commit without full pass");
    a_sc_after: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.sc_latch |-> $past(cmd.cordic_step))
        else $error("sine latched early");

endmodule

// File: hdl/affine_2d_transform_engine_top.sv
// 2d affine transform engine: holds m11 m12 m21 m22 dx dy (signed q16.16 by default,
// reset to identity) and runs one command transaction at a time, chosen by func:
// set, rotate by a binary angle, scale, translate, or map a point. only map point
// gives an output transaction, with saturated x/y and an overflow flag. a command
// keeps in_stall high from its accept through the cordic state (for rotate, 16 cordic
// iterations on one shift-add unit, then a sine/cosine latch), four passes through the
// shared two-multiplier sum unit and a commit; the next command is taken only once
// in_stall falls, so commands never overlap. a map also keeps in_stall high while it
// loads the output register, longer while out_stall holds the previous result there.
module affine_2d_transform_engine_top #(
    parameter int COEF_WIDTH = a2d_pkg::COEF_WIDTH_DEF,
    parameter int FRAC_BITS  = a2d_pkg::FRAC_BITS_DEF,
    parameter int ANGLE_BITS = a2d_pkg::ANGLE_BITS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  a2d_pkg::a2d_in_t  in_data,
    output logic              out_valid,
    input  logic              out_stall,
    output a2d_pkg::a2d_out_t out_data
);
    import a2d_pkg::*;

    // command/status between controller and datapath
    a2d_cmd_t cmd;
    a2d_sts_t sts;

    // sequencer: accept, cordic iterations, sine/cosine latch, four sum passes, commit, output
    a2d_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .sts       (sts),
        .cmd       (cmd)
    );

    // coefficient store, cordic unit, multiply-add-round-saturate unit
    a2d_datapath #(
        .COEF_WIDTH (COEF_WIDTH),
        .FRAC_BITS  (FRAC_BITS),
        .ANGLE_BITS (ANGLE_BITS)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_data  (in_data),
        .cmd      (cmd),
        .sts      (sts),
        .out_data (out_data)
    );

endmodule
